// ===== rtl/ili_pkg.sv =====
package ili_pkg;

    // Field widths of the request and result channels.
    localparam int KIND_W = 3;
    localparam int POS_W  = 16;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_AT_POS = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    // Value returned by a read of an invalid position.
    localparam logic [VAL_W-1:0] READ_MISS = {VAL_W{1'b1}};

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_COMMIT,
        S_RESULT
    } ili_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decide;
        logic rd_pos;
        logic shift_rd;
        logic shift_wr;
        logic commit;
        logic load_result;
    } ili_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_read;
        logic go_insert;
        logic go_delete;
        logic shift_done;
        logic out_free;
    } ili_stat_t;

endpackage

// ===== rtl/ili_ram.sv =====
module ili_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port; read data holds while idle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ili_ctrl.sv =====
module ili_ctrl
    import ili_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ili_stat_t stat,
    output ili_cmd_t  cmd
);

    ili_state_t state_reg;
    ili_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.go_insert || stat.go_delete) begin
                    state_next = S_CHECK;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_CHECK: begin
                if (stat.shift_done) begin
                    state_next = S_COMMIT;
                end else begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_CHECK;
            S_COMMIT:   state_next = S_RESULT;
            S_RESULT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Output logic.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                cmd.rd_pos = stat.go_read;
            end
            S_SHIFT_RD: cmd.shift_rd = 1'b1;
            S_SHIFT_WR: cmd.shift_wr = 1'b1;
            S_COMMIT:   cmd.commit   = 1'b1;
            S_RESULT:   cmd.load_result = stat.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    // A shift read is always followed by its write-back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_rd |=> cmd.shift_wr)
        else $error("shift read not followed by write-back");

    // A new request is only taken while no request is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == S_DECIDE))
        else $error("captured request did not enter decision");

endmodule

// ===== rtl/ili_dp.sv =====
module ili_dp
    import ili_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ili_cmd_t                 cmd,
    output ili_stat_t                stat,
    input  logic [KIND_W-1:0]        s_kind,
    input  logic signed [POS_W-1:0]  s_position,
    input  logic signed [VAL_W-1:0]  s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [VAL_W-1:0]  m_read_value,
    output logic [STAT_W-1:0]        m_status,
    output logic [LEN_W-1:0]         m_list_length
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int EXT_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Captured request.
    logic [KIND_W-1:0] kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  value_reg;

    // List state and shift pointer.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [STAT_W-1:0] code_reg;

    // Result register.
    logic              m_valid_reg;
    logic [VAL_W-1:0]  read_value_reg;
    logic [STAT_W-1:0] status_reg;
    logic [LEN_W-1:0]  length_reg;

    // Decode and position checks.
    logic              is_insert;
    logic              full;
    logic              pos_nonneg;
    logic [POS_W-1:0]  count_wide;
    logic              pos_below;
    logic              pos_upto;
    logic [STAT_W-1:0] code_calc;
    logic [ADDR_W-1:0] ins_target;
    logic [EXT_W-1:0]  count_ext;

    // Memory ports.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [VAL_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [VAL_W-1:0]  ram_rd_data;

    // Request capture on the input transfer.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= s_kind;
            pos_reg   <= s_position;
            value_reg <= s_value;
        end
    end

    // Classify the request against the current length.
    assign is_insert  = (kind_reg == KIND_HEAD) || (kind_reg == KIND_TAIL) ||
                        (kind_reg == KIND_AT_POS);
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign pos_nonneg = !pos_reg[POS_W-1];
    assign count_wide = POS_W'(count_reg);
    assign pos_below  = pos_nonneg && (pos_reg < count_wide);
    assign pos_upto   = pos_nonneg && (pos_reg <= count_wide);

    always_comb begin
        case (kind_reg)
            KIND_READ:   code_calc = pos_below ? STAT_DONE : STAT_INVALID;
            KIND_HEAD:   code_calc = full ? STAT_FULL : STAT_DONE;
            KIND_TAIL:   code_calc = full ? STAT_FULL : STAT_DONE;
            KIND_AT_POS: code_calc = !pos_upto ? STAT_INVALID :
                                     (full ? STAT_FULL : STAT_DONE);
            KIND_DELETE: code_calc = pos_below ? STAT_DONE : STAT_INVALID;
            default:     code_calc = STAT_INVALID;
        endcase
    end

    // Slot that receives the new value of an insert.
    always_comb begin
        case (kind_reg)
            KIND_HEAD:   ins_target = '0;
            KIND_TAIL:   ins_target = count_reg[ADDR_W-1:0];
            default:     ins_target = pos_reg[ADDR_W-1:0];
        endcase
    end

    // Status toward the controller.
    always_comb begin
        stat.go_read   = (kind_reg == KIND_READ) && (code_calc == STAT_DONE);
        stat.go_insert = is_insert && (code_calc == STAT_DONE);
        stat.go_delete = (kind_reg == KIND_DELETE) && (code_calc == STAT_DONE);
        if (is_insert) begin
            stat.shift_done = (ptr_reg == ins_target);
        end else begin
            stat.shift_done = ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg);
        end
        stat.out_free = !m_valid_reg || m_ready;
    end

    // Shift pointer: starts at the end for an insert, at the hole for a delete.
    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.decide) begin
            ptr_next = is_insert ? count_reg[ADDR_W-1:0] : pos_reg[ADDR_W-1:0];
        end else if (cmd.shift_wr) begin
            ptr_next = is_insert ? (ptr_reg - ADDR_W'(1)) : (ptr_reg + ADDR_W'(1));
        end
    end

    // Entry count changes once the shift has finished.
    always_comb begin
        count_next = count_reg;
        if (cmd.commit) begin
            count_next = is_insert ? (count_reg + CNT_W'(1)) : (count_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.decide) begin
            code_reg <= code_calc;
        end
    end

    // Memory access: one entry moves per read and write-back pair.
    assign ram_rd_en   = cmd.rd_pos || cmd.shift_rd;
    assign ram_rd_addr = !cmd.shift_rd ? pos_reg[ADDR_W-1:0] :
                         (is_insert ? (ptr_reg - ADDR_W'(1)) : (ptr_reg + ADDR_W'(1)));
    assign ram_wr_en   = cmd.shift_wr || (cmd.commit && is_insert);
    assign ram_wr_addr = ptr_reg;
    assign ram_wr_data = cmd.shift_wr ? ram_rd_data : value_reg;

    ili_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result register; a new result loads when the register is free or the previous one is taken.
    assign count_ext = EXT_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            if (kind_reg == KIND_READ) begin
                read_value_reg <= (code_reg == STAT_DONE) ? ram_rd_data : READ_MISS;
            end else begin
                read_value_reg <= '0;
            end
            status_reg <= code_reg;
            length_reg <= count_ext[LEN_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = read_value_reg;
    assign m_status      = status_reg;
    assign m_list_length = length_reg;

    // The list never holds more than its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An insert commit grows the list by exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && is_insert) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    // A result is never loaded over one still waiting for transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    // Shifting only happens on a request that passed its checks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_wr |-> (code_reg == STAT_DONE))
        else $error("shift on a refused request");

endmodule

// ===== rtl/indexed_list_insert_delete_top.sv =====
// Indexed list: an ordered list of up to CAPACITY signed 32-bit entries.
// Requests arrive on the s_ channel (s_kind, s_position, s_value) with a
// valid/ready handshake; each request gives exactly one result on the m_
// channel (m_read_value, m_status, m_list_length).
// Kinds: read at position, insert at head, insert at tail, insert before a
// position, delete at position. Refused requests leave the list unchanged.
// One request is handled at a time. A read or a refused request goes from
// its decision straight to its result; an insert or delete moves its entries
// one at a time, since the entries live in a single-port-write RAM and each
// moved entry costs a check, a read and a write-back. The worst case moves
// CAPACITY - 1 entries. The next request is accepted as soon as the
// previous result is loaded.
// The result sits in an output register: the next request is accepted while
// a result still waits, and a stalled m_ready only holds the block once the
// following result is ready to be loaded.
// Reset (aresetn, synchronous, active low) empties the list and drops any
// pending result; the entry RAM itself is not cleared and needs no sweep.
module indexed_list_insert_delete_top
    import ili_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [KIND_W-1:0]       s_kind,
    input  logic signed [POS_W-1:0] s_position,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_read_value,
    output logic [STAT_W-1:0]       m_status,
    output logic [LEN_W-1:0]        m_list_length
);

    ili_cmd_t  cmd;
    ili_stat_t stat;

    // Sequencer for request decision, entry shifting and result hand-off.
    ili_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Entry store, count, shift pointer and result register.
    ili_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_kind        (s_kind),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_status      (m_status),
        .m_list_length (m_list_length)
    );

endmodule
